// ===== hdl/teq_pkg.sv =====
package teq_pkg;
  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W = $clog2(TASK_SLOTS);
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam logic [1:0] REQ_SCHED = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_TIME = 2'd2;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] MS_PER_SEC = 48'd1000;
  // microseconds to milliseconds: x * ceil(2^30 / 1000) >> 30, exact for 20-bit x
  localparam logic [40:0] US_RECIP = 41'd1073742;
  localparam int US_RECIP_SHIFT = 30;

  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic [47:0] due;
    logic [48:0] intv;
    logic        rpt;
    logic        done;
  } slot_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
    logic [31:0]       id;
    logic [47:0]       due;
  } cand_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] id;
    logic [47:0] due;
    logic [48:0] intv;
    logic        rpt;
    logic [47:0] now;
  } cmd_t;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_CLRDONE = 2'd1;
endpackage

// ===== hdl/teq_if.sv =====
interface teq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] time_sec;
  logic [19:0] time_usec;
  logic        repeat_req;
  logic [31:0] cancel_id;
  modport source(output valid, req_type, time_sec, time_usec, repeat_req, cancel_id,
                 input ready);
  modport sink(input valid, req_type, time_sec, time_usec, repeat_req, cancel_id,
               output ready);
endinterface

interface teq_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  status;
  logic [31:0] task_id;
  logic        last;
  modport source(output valid, kind, status, task_id, last, input ready);
  modport sink(input valid, kind, status, task_id, last, output ready);
endinterface

// ===== hdl/teq_cell.sv =====
module teq_cell
  import teq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic              wr_en,
  input  logic              kill,
  input  logic              fire,
  input  logic [SLOT_W-1:0] idx,
  input  cand_t             cand_in,
  output cand_t             cand_out,
  output slot_t             slot
);
  logic        take;
  logic [49:0] sum;
  logic [47:0] due_next;
  cand_t       cand_next;

  always_comb begin
    cand_next = cand_in;
    take = slot.valid && !slot.done && (slot.due <= cmd.now) &&
           (!cand_in.found || slot.due < cand_in.due ||
            (slot.due == cand_in.due && slot.id < cand_in.id));
    if (take) begin
      cand_next.found = 1'b1;
      cand_next.idx = idx;
      cand_next.id = slot.id;
      cand_next.due = slot.due;
    end
    sum = {2'b00, cmd.now} + {slot.intv[48], slot.intv};
    if (sum[49]) due_next = '0;
    else if (sum[48]) due_next = MAX48;
    else due_next = sum[47:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
      slot.done <= 1'b0;
      cand_out <= '0;
    end else begin
      cand_out <= cand_next;
      if (wr_en) begin
        slot.valid <= 1'b1;
        slot.done <= 1'b0;
        slot.id <= cmd.id;
        slot.due <= cmd.due;
        slot.intv <= cmd.intv;
        slot.rpt <= cmd.rpt;
      end else if (kill) begin
        slot.valid <= 1'b0;
      end else if (fire) begin
        slot.done <= 1'b1;
        if (slot.rpt) slot.due <= due_next;
        else slot.valid <= 1'b0;
      end else if (cmd.op == OP_CLRDONE) begin
        slot.done <= 1'b0;
      end
    end
  end
endmodule

// ===== hdl/timed_event_queue.sv =====
// The answer is presented after S_ANS and a search in which the registered slot chain settles;
// each fired report is presented after a further search once the previous result is taken.
// A new request is accepted only in S_IDLE, after the last report of the previous one is taken;
// the registered slot chain settles once per search.
// Reset: synchronous; clears all slots, the time and the id counter.
module timed_event_queue
  import teq_pkg::*;
(
  input logic clk,
  input logic rst,
  teq_in_if.sink   req,
  teq_out_if.source res
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ANS = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0]  state;
  logic [CNT_W-1:0] cnt;
  logic [47:0] now_ms;
  logic [31:0] next_id;
  logic [1:0]  rtype;
  logic [47:0] ms;
  logic        rpt;
  logic [31:0] key;
  cand_t       best;
  cand_t       chain [TASK_SLOTS+1];
  slot_t       slots [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] wr_en, kill, fire;
  cmd_t        cmd;
  logic        free_any, hit_any;
  logic [SLOT_W-1:0] free_idx, hit_idx;
  logic [40:0] usec_prod;
  logic [40-US_RECIP_SHIFT:0] usec_ms;
  logic [47:0] ms_in;

  assign usec_prod = 41'(req.time_usec) * US_RECIP;
  assign usec_ms = usec_prod[40:US_RECIP_SHIFT];
  assign ms_in = 48'(req.time_sec) * MS_PER_SEC + 48'(usec_ms);
  assign req.ready = (state == S_IDLE);

  always_comb begin
    free_any = 1'b0; free_idx = '0; hit_any = 1'b0; hit_idx = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!slots[i].valid) begin free_any = 1'b1; free_idx = SLOT_W'(i); end
      if (slots[i].valid && slots[i].id == key) begin hit_any = 1'b1; hit_idx = SLOT_W'(i); end
    end
    cmd.op = OP_NONE;
    cmd.id = next_id;
    cmd.due = ms;
    cmd.intv = {1'b0, ms} - {1'b0, now_ms};
    cmd.rpt = rpt;
    cmd.now = now_ms;
    wr_en = '0;
    kill = '0;
    fire = '0;
    if (state == S_ANS) begin
      cmd.op = OP_CLRDONE;
      if (rtype == REQ_SCHED && free_any) wr_en[free_idx] = 1'b1;
      if (rtype == REQ_CANCEL && hit_any) kill[hit_idx] = 1'b1;
    end else if (state == S_OUT && res.valid && res.ready && !res.last) begin
      fire[best.idx] = 1'b1;
    end
  end

  assign chain[0] = '0;
  for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
    teq_cell u_cell (
      .clk(clk), .rst(rst), .cmd(cmd), .wr_en(wr_en[g]), .kill(kill[g]),
      .fire(fire[g]), .idx(SLOT_W'(g)),
      .cand_in(chain[g]), .cand_out(chain[g+1]), .slot(slots[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      now_ms <= '0;
      next_id <= '0;
      res.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (req.valid) begin
          rtype <= req.req_type;
          ms <= ms_in;
          rpt <= req.repeat_req;
          key <= req.cancel_id;
          state <= S_ANS;
        end
        S_ANS: begin
          res.kind <= 1'b0;
          case (rtype)
            REQ_SCHED: begin
              if (free_any) begin
                res.status <= ST_OK;
                res.task_id <= next_id;
                next_id <= next_id + 32'd1;
              end else begin
                res.status <= ST_FULL;
                res.task_id <= '0;
              end
            end
            REQ_CANCEL: begin
              res.task_id <= key;
              res.status <= hit_any ? ST_OK : ST_NOTFOUND;
            end
            REQ_TIME: begin
              now_ms <= ms;
              res.status <= ST_OK;
              res.task_id <= '0;
            end
            default: begin
              res.status <= ST_OK;
              res.task_id <= '0;
            end
          endcase
          cnt <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (cnt == CNT_W'(TASK_SLOTS)) begin
            best <= chain[TASK_SLOTS];
            res.valid <= 1'b1;
            res.last <= !chain[TASK_SLOTS].found;
            state <= S_OUT;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_OUT: if (res.ready) begin
          res.valid <= 1'b0;
          if (res.last) begin
            state <= S_IDLE;
          end else begin
            res.kind <= 1'b1;
            res.status <= ST_OK;
            res.task_id <= best.id;
            cnt <= '0;
            state <= S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !res.valid) else $error("ready while result pending");
  a_fire_kind: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind) |-> res.status == ST_OK) else $error("fired report status");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> (res.valid && $stable(res.task_id) && $stable(res.last)))
    else $error("result dropped while stalled");
`endif
endmodule

// ===== tb/tb.sv =====
module tb
  import teq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_FIRED = 1'b1;
  localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic        kind;
    logic [1:0]  status;
    logic [31:0] task_id;
    logic        last;
  } report_t;

  logic clk;
  logic rst;

  teq_in_if  req();
  teq_out_if res();

  timed_event_queue u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res)
  );

  // schedule table mirror
  logic        tbl_valid [TASK_SLOTS];
  logic [31:0] tbl_id    [TASK_SLOTS];
  logic [47:0] tbl_due   [TASK_SLOTS];
  longint      tbl_intv  [TASK_SLOTS];
  logic        tbl_rpt   [TASK_SLOTS];
  logic [47:0] clock_ms;
  logic [31:0] id_counter;

  report_t pending_reports[$];
  int      mismatches;
  int      burst_left;
  longint  cur_sec;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [47:0] to_millis(logic [31:0] sec, logic [19:0] usec);
    longint ms;
    ms = longint'(sec) * 1000 + longint'(usec) / 1000;
    return ms[47:0] & MASK48;
  endfunction

  function automatic void push_report(logic kind, logic [1:0] status, logic [31:0] id);
    report_t r;
    r.kind = kind;
    r.status = status;
    r.task_id = id;
    r.last = 1'b0;
    pending_reports = {pending_reports, r};
  endfunction

  function automatic void predict_request(logic [1:0] rtype, logic [31:0] sec,
                                          logic [19:0] usec, logic rpt,
                                          logic [31:0] key);
    logic [47:0] ms;
    int          free_slot;
    logic [1:0]  st;
    logic        fired [TASK_SLOTS];
    int          best;
    longint      due;
    ms = to_millis(sec, usec);
    free_slot = -1;
    st = ST_NOTFOUND;
    case (rtype)
      REQ_SCHED: begin
        for (int i = TASK_SLOTS - 1; i >= 0; i--)
          if (!tbl_valid[i]) free_slot = i;
        if (free_slot < 0) begin
          push_report(KIND_ANSWER, ST_FULL, 32'd0);
        end else begin
          tbl_valid[free_slot] = 1'b1;
          tbl_id[free_slot] = id_counter;
          tbl_due[free_slot] = ms;
          tbl_intv[free_slot] = longint'(ms) - longint'(clock_ms);
          tbl_rpt[free_slot] = rpt;
          push_report(KIND_ANSWER, ST_OK, id_counter);
          id_counter = id_counter + 32'd1;
        end
      end
      REQ_CANCEL: begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (tbl_valid[i] && tbl_id[i] == key && st != ST_OK) begin
            tbl_valid[i] = 1'b0;
            st = ST_OK;
          end
        end
        push_report(KIND_ANSWER, st, key);
      end
      REQ_TIME: begin
        clock_ms = ms;
        push_report(KIND_ANSWER, ST_OK, 32'd0);
      end
      default: push_report(KIND_ANSWER, ST_OK, 32'd0);
    endcase
    for (int i = 0; i < TASK_SLOTS; i++) fired[i] = 1'b0;
    forever begin
      best = -1;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        if (tbl_valid[i] && !fired[i] && tbl_due[i] <= clock_ms) begin
          if (best < 0 || tbl_due[i] < tbl_due[best] ||
              (tbl_due[i] == tbl_due[best] && tbl_id[i] < tbl_id[best]))
            best = i;
        end
      end
      if (best < 0) break;
      push_report(KIND_FIRED, ST_OK, tbl_id[best]);
      fired[best] = 1'b1;
      if (tbl_rpt[best]) begin
        due = longint'(clock_ms) + tbl_intv[best];
        if (due < 0) due = 0;
        if (due > longint'(MASK48)) due = longint'(MASK48);
        tbl_due[best] = due[47:0];
      end else begin
        tbl_valid[best] = 1'b0;
      end
    end
    pending_reports[pending_reports.size() - 1].last = 1'b1;
  endfunction

  task automatic send_request(logic [1:0] rtype, logic [31:0] sec, logic [19:0] usec,
                              logic rpt, logic [31:0] key);
    if (burst_left == 0) begin
      req.valid = 1'b0;
      repeat ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 20)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    req.valid = 1'b1;
    req.req_type = rtype;
    req.time_sec = sec;
    req.time_usec = usec;
    req.repeat_req = rpt;
    req.cancel_id = key;
    do @(posedge clk); while (!req.ready);
    predict_request(rtype, sec, usec, rpt, key);
    @(negedge clk);
    if (burst_left == 0) req.valid = 1'b0;
  endtask

  task automatic test_basic_requests();
    send_request(REQ_SPARE, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1, 32'hFFFF_FFFF);
    send_request(REQ_TIME, 32'd1, 20'hFFFFF, 1'b0, 32'd0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < TASK_SLOTS; i++)
      send_request(REQ_SCHED, 32'd100, 20'(i * 1000), 1'b0, 32'd0);
    send_request(REQ_SCHED, 32'd100, 20'd0, 1'b0, 32'd0);
    send_request(REQ_CANCEL, 32'd0, 20'd0, 1'b0, 32'd3);
    send_request(REQ_CANCEL, 32'd0, 20'd0, 1'b0, 32'd3);
    send_request(REQ_TIME, 32'd100, 20'd999999, 1'b0, 32'd0);
  endtask

  task automatic test_past_due_repeat();
    send_request(REQ_SCHED, 32'd0, 20'd0, 1'b1, 32'd0);
    send_request(REQ_TIME, 32'd0, 20'd0, 1'b0, 32'd0);
    send_request(REQ_CANCEL, 32'd0, 20'd0, 1'b0, id_counter - 32'd1);
    cur_sec = 0;
  endtask

  task automatic test_random_traffic(int count);
    int          pick;
    int          s;
    logic [31:0] key;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
        if ($urandom_range(0, 15) == 0)
          send_request(REQ_SCHED, $urandom, 20'($urandom), 1'($urandom), $urandom);
        else
          send_request(REQ_SCHED, 32'(cur_sec + $urandom_range(0, 4)), 20'($urandom),
                       1'($urandom), $urandom);
      end else if (pick < 62) begin
        s = $urandom_range(0, TASK_SLOTS - 1);
        key = ($urandom_range(0, 9) < 7 && tbl_valid[s]) ? tbl_id[s] : $urandom;
        send_request(REQ_CANCEL, $urandom, 20'($urandom), 1'($urandom), key);
      end else if (pick < 95) begin
        case ($urandom_range(0, 9))
          0: cur_sec = $urandom;
          1: cur_sec = (cur_sec > 3) ? cur_sec - $urandom_range(0, 3) : 0;
          default: cur_sec = cur_sec + $urandom_range(0, 3);
        endcase
        if (cur_sec > 64'hFFFF_FFF0) cur_sec = 0;
        send_request(REQ_TIME, 32'(cur_sec), 20'($urandom), 1'($urandom), $urandom);
      end else begin
        send_request(REQ_SPARE, $urandom, 20'($urandom), 1'($urandom), $urandom);
      end
    end
  endtask

  // receiver stall pattern, with stretches of no stalling
  logic [15:0] stall_mask;
  int          stall_pos;
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      stall_pos <= 0;
      stall_mask <= 16'hFFFF;
    end else begin
      res.ready <= stall_mask[stall_pos];
      if (stall_pos == 15) begin
        stall_pos <= 0;
        stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom) | 16'h8421;
      end else begin
        stall_pos <= stall_pos + 1;
      end
    end
  end

  always @(posedge clk) begin
    report_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: kind=%0d status=%0d id=%0d last=%0d",
                   res.kind, res.status, res.task_id, res.last);
      end else begin
        want = pending_reports.pop_front();
        if (res.kind !== want.kind || res.status !== want.status ||
            res.task_id !== want.task_id || res.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want kind=%0d status=%0d id=%0d last=%0d, got %0d %0d %0d %0d",
                     want.kind, want.status, want.task_id, want.last,
                     res.kind, res.status, res.task_id, res.last);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.req_type = REQ_SCHED;
    req.time_sec = '0;
    req.time_usec = '0;
    req.repeat_req = 1'b0;
    req.cancel_id = '0;
    mismatches = 0;
    burst_left = 0;
    cur_sec = 0;
    clock_ms = '0;
    id_counter = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_id[i] = '0;
      tbl_due[i] = '0;
      tbl_intv[i] = 0;
      tbl_rpt[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_requests();
    test_full_table();
    test_past_due_repeat();
    test_random_traffic(400);

    req.valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered schedule, cancel, time update and spare requests, a full table,");
    $display("past-due repeating tasks and about 400 random requests with stalls");
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d transactions missing", mismatches,
               pending_reports.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/teq_pkg.sv
hdl/teq_if.sv
hdl/teq_cell.sv
hdl/timed_event_queue.sv
tb/tb.sv
